### sv/pgs_pkg.sv
// pgs_pkg: shared types, constants and helpers of the polar gaussian sampler
// no dependencies; imported by every other file of the block
package pgs_pkg;

    localparam int UNIFORM_W   = 53;
    localparam int SAMPLE_W    = 32;
    localparam int MAG_W       = UNIFORM_W + 1;
    localparam int MAX_TRIES   = 10;
    localparam int TRY_W       = 6;
    localparam int FRAC_BITS   = 26;
    localparam int LOG_BITS    = 40;
    localparam int SAMPLE_SHIFT = 2 * LOG_BITS - FRAC_BITS;
    localparam int W_SHIFT     = 103 - 2 * LOG_BITS;
    localparam int SUM_W       = 2 * UNIFORM_W + 1;
    localparam logic [63:0] TWO_LN2_Q63 = 64'hB17217F7D1CF79AC;

    // one queued pair: magnitudes and signs of v = 2u - 1
    typedef struct packed {
        logic [MAG_W-1:0] mag_a;
        logic             neg_a;
        logic [MAG_W-1:0] mag_b;
        logic             neg_b;
    } pair_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic         start;
        logic [127:0] x;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] root;
    } sqrt_rsp_t;

    // scale a Q.80 magnitude to the sample format, apply sign, saturate
    function automatic logic [SAMPLE_W-1:0] to_sample(logic [127:0] prod, logic neg);
        logic [127:0]        sh;
        logic [63:0]         mag;
        logic [SAMPLE_W-1:0] res;
        sh  = prod >> SAMPLE_SHIFT;
        mag = (sh[127:64] != 64'd0) ? {64{1'b1}} : sh[63:0];
        if (neg)
        begin
            if (mag >= 64'h8000_0000)
                res = 32'h8000_0000;
            else
                res = (~mag[31:0]) + 32'd1;
        end
        else
        begin
            if (mag > 64'h7FFF_FFFF)
                res = 32'h7FFF_FFFF;
            else
                res = mag[31:0];
        end
        return res;
    endfunction

endpackage

### sv/pgs_in_if.sv
// pgs_in_if: input channel carrying a pair of uniform draws
// depends on pgs_pkg
interface pgs_in_if import pgs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [UNIFORM_W-1:0] uniform_a;
    logic [UNIFORM_W-1:0] uniform_b;

    modport source (output valid, output uniform_a, output uniform_b, input ready);
    modport sink   (input valid, input uniform_a, input uniform_b, output ready);
endinterface

### sv/pgs_out_if.sv
// pgs_out_if: output channel carrying one normal deviate and its bad flag
// depends on pgs_pkg
interface pgs_out_if import pgs_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                bad_draw;

    modport source (output valid, output sample, output bad_draw, input ready);
    modport sink   (input valid, input sample, input bad_draw, output ready);
endinterface

### sv/pgs_mul64.sv
// pgs_mul64: 64x64 unsigned multiplier, one 32x32 partial product per cycle
// depends on pgs_pkg
module pgs_mul64 import pgs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [6:0]   shift;

    // partial product selection
    always_comb
    begin
        a_half = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
        b_half = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
        pp     = {32'd0, a_half} * {32'd0, b_half};
        shift  = {({1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]}), 5'd0};
    end

    // accumulate four partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                a_reg    <= req.a;
                b_reg    <= req.b;
                acc_reg  <= 128'd0;
                cnt_reg  <= 2'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_reg + ({64'd0, pp} << shift);
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

### sv/pgs_isqrt.sv
// pgs_isqrt: floor square root of a 128-bit value, one root bit per cycle
// depends on pgs_pkg
module pgs_isqrt import pgs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic [127:0] x_reg;
    logic [67:0]  rem_reg;
    logic [63:0]  root_reg;
    logic [5:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [67:0]  rem_sh;
    logic [67:0]  trial;

    // restoring step on two radicand bits
    always_comb
    begin
        rem_sh = {rem_reg[65:0], x_reg[127:126]};
        trial  = {2'b00, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                x_reg    <= req.x;
                rem_reg  <= 68'd0;
                root_reg <= 64'd0;
                cnt_reg  <= 6'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                x_reg <= {x_reg[125:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

### sv/pgs_front.sv
// pgs_front: accepts uniform pairs, forms |2u-1| and sign, two-entry queue
// depends on pgs_pkg and pgs_in_if
module pgs_front import pgs_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    pgs_in_if.sink         in_ch,
    input  logic           pop,
    output logic           head_valid,
    output pair_t          head
);

    localparam logic [MAG_W-1:0] HALF2 = MAG_W'(1) << UNIFORM_W;

    pair_t       q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    pair_t       item;
    logic [MAG_W-1:0] two_a;
    logic [MAG_W-1:0] two_b;
    logic        push;

    // classify the incoming pair
    always_comb
    begin
        two_a      = {in_ch.uniform_a, 1'b0};
        two_b      = {in_ch.uniform_b, 1'b0};
        item.neg_a = ~in_ch.uniform_a[UNIFORM_W-1];
        item.neg_b = ~in_ch.uniform_b[UNIFORM_W-1];
        item.mag_a = item.neg_a ? (HALF2 - two_a) : (two_a - HALF2);
        item.mag_b = item.neg_b ? (HALF2 - two_b) : (two_b - HALF2);
    end

    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign head_valid  = (count_reg != 2'd0);
    assign head        = q_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

### sv/pgs_back.sv
// pgs_back: sequencer that tests and transforms one pair, holds the partner
// depends on pgs_pkg, pgs_out_if; drives the shared multiplier and square root
module pgs_back import pgs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  pair_t     head,
    output logic      pop,
    output mul_req_t  mul_req,
    input  mul_rsp_t  mul_rsp,
    output sqrt_req_t sqrt_req,
    input  sqrt_rsp_t sqrt_rsp,
    pgs_out_if.source out_ch
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ1, ST_SQ2, ST_CHK, ST_NORM, ST_LOG, ST_TPREP, ST_WMUL,
        ST_GSQ, ST_RSQ, ST_DIV1, ST_DIV2, ST_OM1, ST_OM2, ST_EMIT
    } state_t;

    state_t              state_reg;
    logic                phase_reg;
    logic [SAMPLE_W-1:0] partner_reg;
    logic                partner_bad_reg;
    logic [TRY_W-1:0]    try_reg;

    logic [SUM_W-1:0]    sum_reg;
    logic [105:0]        norm_reg;
    logic [6:0]          p_reg;
    logic [LOG_BITS-1:0] f_reg;
    logic [5:0]          lcnt_reg;
    logic [63:0]         g_reg;
    logic [63:0]         r_reg;
    logic [63:0]         rem_reg;
    logic [LOG_BITS+1:0] q_reg;
    logic [5:0]          dcnt_reg;
    logic [LOG_BITS+1:0] c1_reg;
    logic [SAMPLE_W-1:0] s1_reg;

    logic                mul_start_reg;
    logic [63:0]         mul_a_reg;
    logic [63:0]         mul_b_reg;
    logic                sqrt_start_reg;
    logic [127:0]        sqrt_x_reg;

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic                out_bad_reg;

    logic                out_free;
    logic                reject;
    logic [TRY_W-1:0]    try_inc;
    logic                limit;
    logic [5:0]          kk;
    logic [63:0]         mm;
    logic [63:0]         t_val;
    logic [63:0]         rem_in;
    logic [LOG_BITS+1:0] q_in;
    logic                d_ge;
    logic [63:0]         n1;
    logic [63:0]         n2;

    // decode and datapath helpers
    always_comb
    begin
        out_free = !out_valid_reg || out_ch.ready;
        reject   = (sum_reg == '0) || sum_reg[SUM_W-1];
        try_inc  = try_reg + TRY_W'(1);
        limit    = (try_inc >= TRY_W'(MAX_TRIES));
        kk       = 6'((7'd125 - p_reg) >> 1);
        mm       = mul_rsp.product[125:62];
        t_val    = ({57'd0, 7'(7'd106 - p_reg)} << LOG_BITS) - {24'd0, f_reg};
        rem_in   = (dcnt_reg == 6'd0) ? rem_reg : {rem_reg[62:0], 1'b0};
        q_in     = {q_reg[LOG_BITS:0], 1'b0};
        d_ge     = (rem_in >= r_reg);
        n1       = {10'd0, head.mag_a} << kk;
        n2       = {10'd0, head.mag_b} << kk;
    end

    // queue pop
    always_comb
    begin
        pop = 1'b0;
        case (state_reg)
            ST_IDLE: pop = head_valid && phase_reg && out_free;
            ST_CHK:  pop = reject && (!limit || out_free);
            ST_EMIT: pop = out_free;
            default: pop = 1'b0;
        endcase
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= 1'b0;
            partner_reg     <= '0;
            partner_bad_reg <= 1'b0;
            try_reg         <= '0;
            mul_start_reg   <= 1'b0;
            sqrt_start_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            lcnt_reg        <= 6'd0;
            dcnt_reg        <= 6'd0;
        end
        else
        begin
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            if (out_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid && phase_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_sample_reg <= partner_reg;
                            out_bad_reg    <= partner_bad_reg;
                            phase_reg      <= 1'b0;
                        end
                    end
                    else if (head_valid)
                    begin
                        mul_start_reg <= 1'b1;
                        mul_a_reg     <= {10'd0, head.mag_a};
                        mul_b_reg     <= {10'd0, head.mag_a};
                        state_reg     <= ST_SQ1;
                    end
                end

                ST_SQ1:
                begin
                    if (mul_rsp.done)
                    begin
                        sum_reg       <= mul_rsp.product[SUM_W-1:0];
                        mul_start_reg <= 1'b1;
                        mul_a_reg     <= {10'd0, head.mag_b};
                        mul_b_reg     <= {10'd0, head.mag_b};
                        state_reg     <= ST_SQ2;
                    end
                end

                ST_SQ2:
                begin
                    if (mul_rsp.done)
                    begin
                        sum_reg   <= sum_reg + mul_rsp.product[SUM_W-1:0];
                        state_reg <= ST_CHK;
                    end
                end

                ST_CHK:
                begin
                    if (reject)
                    begin
                        if (!limit)
                        begin
                            try_reg   <= try_inc;
                            state_reg <= ST_IDLE;
                        end
                        else if (out_free)
                        begin
                            // retry limit: bad zero now, bad partner next
                            try_reg         <= '0;
                            partner_reg     <= '0;
                            partner_bad_reg <= 1'b1;
                            phase_reg       <= 1'b1;
                            out_valid_reg   <= 1'b1;
                            out_sample_reg  <= '0;
                            out_bad_reg     <= 1'b1;
                            state_reg       <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        try_reg   <= '0;
                        norm_reg  <= sum_reg[105:0];
                        p_reg     <= 7'd105;
                        state_reg <= ST_NORM;
                    end
                end

                // leading-one search, eight or one position per cycle
                ST_NORM:
                begin
                    if (norm_reg[105])
                    begin
                        f_reg         <= '0;
                        lcnt_reg      <= 6'd0;
                        mul_start_reg <= 1'b1;
                        mul_a_reg     <= {1'b0, norm_reg[105:43]};
                        mul_b_reg     <= {1'b0, norm_reg[105:43]};
                        state_reg     <= ST_LOG;
                    end
                    else if (norm_reg[105:98] == 8'd0)
                    begin
                        norm_reg <= {norm_reg[97:0], 8'd0};
                        p_reg    <= p_reg - 7'd8;
                    end
                    else
                    begin
                        norm_reg <= {norm_reg[104:0], 1'b0};
                        p_reg    <= p_reg - 7'd1;
                    end
                end

                // log2 fraction by repeated squaring
                ST_LOG:
                begin
                    if (mul_rsp.done)
                    begin
                        if (mm[63])
                        begin
                            f_reg     <= {f_reg[LOG_BITS-2:0], 1'b1};
                            mul_a_reg <= {1'b0, mm[63:1]};
                            mul_b_reg <= {1'b0, mm[63:1]};
                        end
                        else
                        begin
                            f_reg     <= {f_reg[LOG_BITS-2:0], 1'b0};
                            mul_a_reg <= mm;
                            mul_b_reg <= mm;
                        end
                        lcnt_reg <= lcnt_reg + 6'd1;
                        if (lcnt_reg == 6'(LOG_BITS - 1))
                            state_reg <= ST_TPREP;
                        else
                            mul_start_reg <= 1'b1;
                    end
                end

                ST_TPREP:
                begin
                    mul_start_reg <= 1'b1;
                    mul_a_reg     <= t_val;
                    mul_b_reg     <= TWO_LN2_Q63;
                    state_reg     <= ST_WMUL;
                end

                ST_WMUL:
                begin
                    if (mul_rsp.done)
                    begin
                        sqrt_start_reg <= 1'b1;
                        sqrt_x_reg     <= mul_rsp.product >> W_SHIFT;
                        state_reg      <= ST_GSQ;
                    end
                end

                ST_GSQ:
                begin
                    if (sqrt_rsp.done)
                    begin
                        g_reg          <= sqrt_rsp.root;
                        sqrt_start_reg <= 1'b1;
                        sqrt_x_reg     <= {21'd0, sum_reg} << {kk, 1'b0};
                        state_reg      <= ST_RSQ;
                    end
                end

                ST_RSQ:
                begin
                    if (sqrt_rsp.done)
                    begin
                        r_reg     <= sqrt_rsp.root;
                        rem_reg   <= n1;
                        q_reg     <= '0;
                        dcnt_reg  <= 6'd0;
                        state_reg <= ST_DIV1;
                    end
                end

                // restoring division, one quotient bit per cycle
                ST_DIV1, ST_DIV2:
                begin
                    rem_reg  <= d_ge ? (rem_in - r_reg) : rem_in;
                    q_reg    <= d_ge ? (q_in | (LOG_BITS+2)'(1)) : q_in;
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'(LOG_BITS))
                    begin
                        dcnt_reg <= 6'd0;
                        if (state_reg == ST_DIV1)
                        begin
                            c1_reg    <= d_ge ? (q_in | (LOG_BITS+2)'(1)) : q_in;
                            rem_reg   <= n2;
                            q_reg     <= '0;
                            state_reg <= ST_DIV2;
                        end
                        else
                        begin
                            mul_start_reg <= 1'b1;
                            mul_a_reg     <= 64'(c1_reg);
                            mul_b_reg     <= g_reg;
                            q_reg         <= d_ge ? (q_in | (LOG_BITS+2)'(1)) : q_in;
                            state_reg     <= ST_OM1;
                        end
                    end
                end

                ST_OM1:
                begin
                    if (mul_rsp.done)
                    begin
                        s1_reg        <= to_sample(mul_rsp.product, head.neg_a);
                        mul_start_reg <= 1'b1;
                        mul_a_reg     <= 64'(q_reg);
                        mul_b_reg     <= g_reg;
                        state_reg     <= ST_OM2;
                    end
                end

                ST_OM2:
                begin
                    if (mul_rsp.done)
                    begin
                        partner_reg     <= to_sample(mul_rsp.product, head.neg_b);
                        partner_bad_reg <= 1'b0;
                        state_reg       <= ST_EMIT;
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= s1_reg;
                        out_bad_reg    <= 1'b0;
                        phase_reg      <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign mul_req.start  = mul_start_reg;
    assign mul_req.a      = mul_a_reg;
    assign mul_req.b      = mul_b_reg;
    assign sqrt_req.start = sqrt_start_reg;
    assign sqrt_req.x     = sqrt_x_reg;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.sample   = out_sample_reg;
    assign out_ch.bad_draw = out_bad_reg;

endmodule

### sv/polar_gaussian_sampler.sv
// polar_gaussian_sampler: top level of the polar-method normal deviate generator
// depends on pgs_pkg, pgs_in_if, pgs_out_if, pgs_front, pgs_back, pgs_mul64, pgs_isqrt
//
//  channel  dir  payload                          transaction
//  in_ch    in   uniform_a[52:0], uniform_b[52:0] one uniform pair
//  out_ch   out  sample[31:0] (Q5.26), bad_draw   one deviate
//
// an accepted pair is normalized, then takes 40 squarings on the shared
// multiplier (4 partial products each), two square roots and two divisions
// a two-entry queue keeps accepting pairs while the sequencer works
// the output register holds a deviate until taken; the sequencer stalls only
// when it has a new deviate and that register is still full
// reset clears phase, partner, retry count and all handshake state
module polar_gaussian_sampler import pgs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pgs_in_if.sink    in_ch,
    pgs_out_if.source out_ch
);

    logic      pop;
    logic      head_valid;
    pair_t     head;
    mul_req_t  mul_req;
    mul_rsp_t  mul_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    pgs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    pgs_mul64 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    pgs_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    pgs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .mul_req    (mul_req),
        .mul_rsp    (mul_rsp),
        .sqrt_req   (sqrt_req),
        .sqrt_rsp   (sqrt_rsp),
        .out_ch     (out_ch)
    );

endmodule
